[sv/modular_inverse_euclid_macros.svh]
// Assertion macros for the verification file of the modular inverse block.
`ifndef MODULAR_INVERSE_EUCLID_MACROS_SVH
`define MODULAR_INVERSE_EUCLID_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MIE_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("modular inverse check failed");

// The consequent must hold in the cycle after the antecedent.
`define MIE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("modular inverse check failed");

`endif

[sv/mie_pkg.sv]
package mie_pkg;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] modulus;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] inverse;
      logic        not_coprime;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic update;
      logic emit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic b_zero;
      logic rem_zero;
   } dp_status_type;

endpackage

[sv/modular_inverse_euclid.sv]
// Modular inverse by the extended Euclidean algorithm. Each transfer on the request channel
// carries a value and a modulus, both taken in their low OPERAND_WIDTH bits, and produces
// exactly one transfer on the response channel holding the inverse in the range 0 to
// modulus-1 and a flag that is set when the gcd of the two operands is not 1, in which case
// the inverse field has no meaning. A zero modulus, or a value that the modulus divides,
// gives an inverse of 0. The block works on one item at a time: a request is taken only
// when the engine is idle, which may be while the previous result still waits in the
// response register. Each Euclid step passes through the check state, the bit-serial
// restoring divider in the divide state and the update state, and the next request can be
// taken in the same cycle as the earliest response transfer; a zero modulus needs no step.
// For 32-bit operands an item needs at most about 47 steps.
module modular_inverse_euclid #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mie_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mie_pkg::rsp_payload_type rsp_data
);
   import mie_pkg::*;

   // The controller sequences the steps; the datapath holds the operands, the running
   // Bezout coefficients and the response register.
   dp_cmd_type    cmd;
   dp_status_type status;

   mie_controller #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_controller (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // The coefficients are held two bits wider than the operands, which is enough for
   // their true magnitude, so the wrap-around arithmetic is exact.
   mie_datapath #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_datapath (
      .clock   (clock),
      .cmd     (cmd),
      .req_data(req_data),
      .status  (status),
      .rsp_data(rsp_data)
   );

endmodule

[sv/mie_datapath.sv]
module mie_datapath #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                     clock,
   input  mie_pkg::dp_cmd_type      cmd,
   input  mie_pkg::req_payload_type req_data,
   output mie_pkg::dp_status_type   status,
   output mie_pkg::rsp_payload_type rsp_data
);
   import mie_pkg::*;

   localparam int W = OPERAND_WIDTH;

   logic [W-1:0]    a_ff, a_in;
   logic [W-1:0]    b_ff, b_in;
   logic [W-1:0]    m_ff, m_in;
   logic [W+1:0]    x_ff, x_in;
   logic [W+1:0]    px_ff, px_in;
   logic [W+1:0]    d_ff, d_in;
   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    quo_ff, quo_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [W:0]      shifted;
   logic [W+1:0]    diff;
   logic            qbit;
   logic [W+1:0]    folded;

   // One restoring division step; the negated product -x*q is built alongside by Horner's rule.
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, b_ff};
   assign qbit    = ~diff[W+1];

   assign folded = x_ff[W+1] ? (x_ff + {2'b00, m_ff}) : x_ff;

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      m_in   = m_ff;
      x_in   = x_ff;
      px_in  = px_ff;
      d_in   = d_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      rsp_in = rsp_ff;
      if (cmd.load) begin
         a_in  = W'(req_data.value);
         b_in  = W'(req_data.modulus);
         m_in  = W'(req_data.modulus);
         x_in  = '0;
         px_in = (W+2)'(1);
      end
      if (cmd.div_init) begin
         rem_in = '0;
         quo_in = a_ff;
         d_in   = '0;
      end
      if (cmd.div_step) begin
         rem_in = qbit ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], qbit};
         d_in   = {d_ff[W:0], 1'b0} - (qbit ? x_ff : '0);
      end
      if (cmd.update) begin
         a_in = b_ff;
         b_in = rem_ff;
         if (rem_ff != '0) begin
            x_in  = px_ff + d_ff;
            px_in = x_ff;
         end
      end
      if (cmd.emit) begin
         rsp_in.inverse     = 32'(folded);
         rsp_in.not_coprime = (a_ff != W'(1));
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      x_ff   <= x_in;
      px_ff  <= px_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      rsp_ff <= rsp_in;
   end

   assign status.b_zero   = (b_ff == '0);
   assign status.rem_zero = (rem_ff == '0);
   assign rsp_data        = rsp_ff;

endmodule

[sv/mie_controller.sv]
module mie_controller #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  mie_pkg::dp_status_type status,
   output mie_pkg::dp_cmd_type    cmd
);
   import mie_pkg::*;

   localparam int COUNT_WIDTH = $clog2(OPERAND_WIDTH);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.b_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_init = 1'b1;
               count_in     = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + COUNT_WIDTH'(1);
            if (count_ff == COUNT_WIDTH'(OPERAND_WIDTH - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.rem_zero ? ST_DONE : ST_CHECK;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/mie_checker.sv]
`include "modular_inverse_euclid_macros.svh"

module mie_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input mie_pkg::rsp_payload_type rsp_data
);
   import mie_pkg::*;

   // A stalled response stays offered.
   `MIE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A stalled response keeps its payload.
   `MIE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

   // The engine is busy in the cycle after it takes a request.
   `MIE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A new response never appears directly after a request transfer.
   `MIE_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && !req_stall,
                    !$rose(rsp_valid))

   // A fresh response is only raised while the engine is still busy.
   `MIE_ASSERT_SAME(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind modular_inverse_euclid mie_checker u_checker (.*);
